// ----- hdl/i2cm_pkg.sv -----
package i2cm_pkg;

  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned CHECK_SAMPLES = 16;

  localparam logic [4:0] BITS2 = 5'(2 * BYTE_BITS);
  localparam logic [4:0] CHECK_SAMPLING_STEP = 5'd5;
  localparam logic [7:0] CHECK_LIMIT = 8'(CHECK_SAMPLES);

  // request codes carried in req_type
  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_START = 3'd1;
  localparam logic [2:0] REQ_CHECK = 3'd5;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_CHECK = 3'd5
  } op_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] tx_byte;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic       ack_ok;
    logic [7:0] rx_byte;
    logic       bus_clear;
  } res_t;

  typedef struct packed {
    op_e        op;
    logic [4:0] phase_step;
    logic [7:0] shift_reg;
    logic [7:0] tick_count;
    logic       scl;
    logic       sda;
    logic       sda_dir;
    logic       ack;
    logic [7:0] rx;
    logic       clear;
  } eng_state_t;

endpackage

// ----- hdl/i2c_master_byte_engine_top.sv -----
// I2C master pin sequencer, one result item for every input item.
// Input channel (in_valid_i / in_stall_o / in_data_i): a transfer carries a
// command (start, stop, write byte, read byte, bus check) or a tick with the
// sampled SDA level. Commands are taken only while idle; ticks step the
// SCL/SDA sequence once every phase_ticks ticks (a phase_ticks of zero acts as one).
// Output channel (out_valid_o / out_stall_i / out_data_o): pin levels and
// status after that item, ack, received byte and bus-clear flag.
// Configuration: cfg_we_i writes cfg_data_i into phase_ticks; write only
// while no result is outstanding.
// Each input transfer's result is registered in the output queue; one item
// is accepted every cycle while in_stall_o is low, the state update being
// combinational and feeding a two-entry output queue. A stalled receiver
// lets two results pile up, after which in_stall_o rises until one is taken.
// Reset: engine idle, SCL and SDA high, SDA released, phase_ticks one,
// output queue empty.
module i2c_master_byte_engine_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  i2cm_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output i2cm_pkg::res_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_data_i
);
  import i2cm_pkg::*;

  eng_state_t state_q, state_d;
  res_t       res;
  logic [7:0] phase_ticks_q;
  logic       accept;
  logic       full;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  i2cm_step u_step (
    .state_i       (state_q),
    .req_i         (in_data_i),
    .phase_ticks_i (phase_ticks_q),
    .state_o       (state_d),
    .res_o         (res)
  );

  i2cm_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= 8'd1;
    end else if (cfg_we_i) begin
      phase_ticks_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.op         <= OP_IDLE;
      state_q.phase_step <= 5'd0;
      state_q.shift_reg  <= 8'd0;
      state_q.tick_count <= 8'd0;
      state_q.scl        <= 1'b1;
      state_q.sda        <= 1'b1;
      state_q.sda_dir    <= 1'b0;
      state_q.ack        <= 1'b0;
      state_q.rx         <= 8'd0;
      state_q.clear      <= 1'b0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/i2cm_step.sv -----
module i2cm_step (
  input  i2cm_pkg::eng_state_t state_i,
  input  i2cm_pkg::req_t       req_i,
  input  logic [7:0]           phase_ticks_i,
  output i2cm_pkg::eng_state_t state_o,
  output i2cm_pkg::res_t       res_o
);
  import i2cm_pkg::*;

  eng_state_t n;
  logic       done;
  logic       fin;
  logic [7:0] limit;
  logic [7:0] tick_inc;
  logic [4:0] ps;

  always_comb begin
    n        = state_i;
    done     = 1'b0;
    fin      = 1'b0;
    ps       = state_i.phase_step;
    limit    = (phase_ticks_i == 8'd0) ? 8'd1 : phase_ticks_i;
    tick_inc = state_i.tick_count + 8'd1;
    if (req_i.req_type == REQ_TICK) begin
      if (state_i.op != OP_IDLE) begin
        if (state_i.op == OP_CHECK && ps >= CHECK_SAMPLING_STEP) begin
          // sampling window: one sample per tick
          if (!req_i.sda_in) begin
            n.clear   = 1'b0;
            n.sda_dir = 1'b1;
            fin       = 1'b1;
          end else begin
            n.tick_count = tick_inc;
            if (tick_inc >= CHECK_LIMIT) begin
              n.clear   = 1'b1;
              n.sda_dir = 1'b1;
              fin       = 1'b1;
            end
          end
        end else begin
          n.tick_count = tick_inc;
          if (tick_inc >= limit) begin
            n.tick_count = 8'd0;
            unique case (state_i.op)
              OP_START: begin
                priority if (ps == 5'd0) n.scl = 1'b0;
                else if (ps == 5'd1) begin
                  n.sda_dir = 1'b1;
                  n.sda     = 1'b1;
                end else if (ps == 5'd2) n.scl = 1'b1;
                else if (ps == 5'd3) n.sda = 1'b0;
                else begin
                  n.scl = 1'b0;
                  fin   = 1'b1;
                end
              end
              OP_STOP, OP_CHECK: begin
                priority if (ps == 5'd0) n.scl = 1'b0;
                else if (ps == 5'd1) begin
                  n.sda_dir = 1'b1;
                  n.sda     = 1'b0;
                end else if (ps == 5'd2) n.scl = 1'b1;
                else if (ps == 5'd3) begin
                  n.sda = 1'b1;
                  fin   = (state_i.op == OP_STOP);
                end else begin
                  n.sda     = 1'b1;
                  n.sda_dir = 1'b0;
                end
              end
              OP_WRITE: begin
                priority if (ps < BITS2) begin
                  if (!ps[0]) begin
                    n.scl       = 1'b0;
                    n.sda_dir   = 1'b1;
                    n.sda       = state_i.shift_reg[7];
                    n.shift_reg = {state_i.shift_reg[6:0], 1'b0};
                  end else begin
                    n.scl = 1'b1;
                  end
                end else if (ps == BITS2) begin
                  n.scl     = 1'b0;
                  n.sda     = 1'b1;
                  n.sda_dir = 1'b0;
                end else if (ps == BITS2 + 5'd1) n.scl = 1'b1;
                else begin
                  n.ack     = !req_i.sda_in;
                  n.scl     = 1'b0;
                  n.sda_dir = 1'b1;
                  fin       = 1'b1;
                end
              end
              OP_READ: begin
                priority if (ps == 5'd0) begin
                  n.sda     = 1'b1;
                  n.sda_dir = 1'b0;
                end else if (ps <= BITS2) begin
                  if (ps[0]) n.scl = 1'b1;
                  else begin
                    n.shift_reg = {state_i.shift_reg[6:0], req_i.sda_in};
                    n.scl       = 1'b0;
                  end
                end else begin
                  n.sda_dir = 1'b1;
                  n.rx      = state_i.shift_reg;
                  fin       = 1'b1;
                end
              end
              default: fin = 1'b1;
            endcase
            if (!fin) n.phase_step = ps + 5'd1;
          end
        end
        if (fin) begin
          n.op         = OP_IDLE;
          n.phase_step = 5'd0;
          n.tick_count = 8'd0;
          done         = 1'b1;
        end
      end
    end else if (req_i.req_type >= REQ_START && req_i.req_type <= REQ_CHECK
                 && state_i.op == OP_IDLE) begin
      n.op         = op_e'(req_i.req_type);
      n.phase_step = 5'd0;
      n.tick_count = 8'd0;
      n.shift_reg  = (op_e'(req_i.req_type) == OP_WRITE) ? req_i.tx_byte : 8'd0;
    end
  end

  assign state_o = n;

  always_comb begin
    res_o.scl_level = n.scl;
    res_o.sda_level = n.sda;
    res_o.sda_drive = n.sda_dir;
    res_o.busy_res  = (n.op != OP_IDLE);
    res_o.done_res  = done;
    res_o.ack_ok    = n.ack;
    res_o.rx_byte   = n.rx;
    res_o.bus_clear = n.clear;
  end

endmodule

// ----- hdl/i2cm_out_buf.sv -----
module i2cm_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  i2cm_pkg::res_t data_i,
  output logic           full_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output i2cm_pkg::res_t out_data_o
);
  import i2cm_pkg::*;

  res_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign out_valid_o = (count_q != 2'd0);
  assign full_o      = (count_q == 2'd2);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

// ----- hdl/i2cm_checker.sv -----
module i2cm_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input i2cm_pkg::req_t in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input i2cm_pkg::res_t out_data_o,
  input logic           cfg_we_i,
  input logic [7:0]     cfg_data_i
);
  import i2cm_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // a transfer into an empty queue shows up as a result in the following cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> out_valid_o)
    else $error("result missing after transfer");

  // completion clears busy
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> !out_data_o.busy_res)
    else $error("done while still busy");

  // every operation ends with SDA driven again
  a_done_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> out_data_o.sda_drive)
    else $error("operation ended with SDA released");

endmodule

bind i2c_master_byte_engine_top i2cm_checker u_i2cm_checker (.*);
